// ===== src/priority_stack_lifo_ties_assert.svh =====
// assertion macros for the priority stack checks
`ifndef PRIORITY_STACK_LIFO_TIES_ASSERT_SVH
`define PRIORITY_STACK_LIFO_TIES_ASSERT_SVH

// condition holds at every edge out of reset
`define PSLT_ASSERT_HOLDS(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("priority stack check failed");

// consequence holds in the same cycle as the antecedent
`define PSLT_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("priority stack check failed");

// consequence holds in the cycle after the antecedent
`define PSLT_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("priority stack check failed");

`endif

// ===== src/pslt_pkg.sv =====
// shared constants and codes for the priority stack
`default_nettype none

package pslt_pkg;

   localparam int DEPTH_DEFAULT       = 16;
   localparam int PRIO_WIDTH_DEFAULT  = 8;
   localparam int VALUE_WIDTH_DEFAULT = 32;

   localparam int KIND_W      = 2;
   localparam int STATUS_W    = 2;
   localparam int OUT_VALUE_W = 32;
   localparam int FILL_W      = 5;
   localparam int RSP_USED_W  = OUT_VALUE_W + 1 + FILL_W;
   localparam int RSP_DATA_W  = ((RSP_USED_W + 7) / 8) * 8;
   localparam int RSP_PAD_W   = RSP_DATA_W - RSP_USED_W;

   localparam logic [KIND_W-1:0] KIND_PUSH  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_POP   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

endpackage

`default_nettype wire

// ===== src/pslt_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
`default_nettype none

module pslt_ram #(
   parameter int WIDTH = pslt_pkg::PRIO_WIDTH_DEFAULT + pslt_pkg::VALUE_WIDTH_DEFAULT,
   parameter int DEPTH = pslt_pkg::DEPTH_DEFAULT,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ===== src/priority_stack_lifo_ties.sv =====
// priority stack: a pop returns the highest priority, latest pushed among ties
// push, clear and other kinds: the result is valid in the cycle after the word is taken
// pop: the accepting cycle issues the read of the top entry, the scan state reads down to
//   the bottom and keeps the best, the shift state moves the entries above it one place
//   down to close the gap, and the finish state loads the result once the slot is free
// a new word is taken only in the idle state with a free result slot; the entry ram has a single read port
// reset clears the fill count and the handshake state; the entry ram is not cleared
`default_nettype none

module priority_stack_lifo_ties #(
   parameter int DEPTH       = pslt_pkg::DEPTH_DEFAULT,
   parameter int PRIO_WIDTH  = pslt_pkg::PRIO_WIDTH_DEFAULT,
   parameter int VALUE_WIDTH = pslt_pkg::VALUE_WIDTH_DEFAULT,
   localparam int REQ_DATA_W = ((PRIO_WIDTH + VALUE_WIDTH + 7) / 8) * 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [REQ_DATA_W-1:0]           req_tdata,  // priority_req, value
   input  logic [pslt_pkg::KIND_W-1:0]     req_tuser,  // kind
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [pslt_pkg::RSP_DATA_W-1:0] rsp_tdata,  // out_value, is_empty, fill_count
   output logic [pslt_pkg::STATUS_W-1:0]   rsp_tuser   // status
);

   `include "priority_stack_lifo_ties_assert.svh"

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int EW = PRIO_WIDTH + VALUE_WIDTH;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_SHIFT  = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [1:0]             state_ff, state_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [AW-1:0]          addr_ff, addr_in;
   logic [AW-1:0]          best_idx_ff, best_idx_in;
   logic [PRIO_WIDTH-1:0]  best_prio_ff, best_prio_in;
   logic [VALUE_WIDTH-1:0] best_val_ff, best_val_in;
   logic                   first_ff, first_in;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic [pslt_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [pslt_pkg::STATUS_W-1:0]   rsp_user_ff, rsp_user_in;
   logic                            rsp_load;

   logic                   ram_we, ram_re;
   logic [AW-1:0]          ram_waddr, ram_raddr;
   logic [EW-1:0]          ram_wdata, ram_rdata;

   logic                   accept, slot_free;
   logic [PRIO_WIDTH-1:0]  req_prio, rd_prio;
   logic [VALUE_WIDTH-1:0] req_value, rd_val;
   logic [CW-1:0]          count_dec;
   logic [AW-1:0]          count_m1;
   logic                   take;
   logic [AW-1:0]          scan_idx;
   logic [PRIO_WIDTH-1:0]  scan_prio;
   logic [VALUE_WIDTH-1:0] scan_val;
   logic [VALUE_WIDTH-1:0] res_val;
   logic [CW-1:0]          res_count;
   logic                   finish_go;
   logic                   idle_rsp;

   assign req_prio  = req_tdata[PRIO_WIDTH-1:0];
   assign req_value = req_tdata[PRIO_WIDTH +: VALUE_WIDTH];
   assign rd_prio   = ram_rdata[PRIO_WIDTH-1:0];
   assign rd_val    = ram_rdata[PRIO_WIDTH +: VALUE_WIDTH];

   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && slot_free;
   assign accept     = req_tvalid && req_tready;

   assign count_dec = count_ff - CW'(1);
   assign count_m1  = count_dec[AW-1:0];

   // scan runs downward, so only a strictly greater priority displaces the candidate
   assign take      = first_ff || (rd_prio > best_prio_ff);
   assign scan_idx  = take ? addr_ff : best_idx_ff;
   assign scan_prio = take ? rd_prio : best_prio_ff;
   assign scan_val  = take ? rd_val  : best_val_ff;

   pslt_ram #(
      .WIDTH (EW),
      .DEPTH (DEPTH)
   ) u_entry_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      addr_in      = addr_ff;
      best_idx_in  = best_idx_ff;
      best_prio_in = best_prio_ff;
      best_val_in  = best_val_ff;
      first_in     = first_ff;
      ram_we       = 1'b0;
      ram_waddr    = count_ff[AW-1:0];
      ram_wdata    = {req_value, req_prio};
      ram_re       = 1'b0;
      ram_raddr    = count_m1;
      rsp_load     = 1'b0;
      res_val      = '0;
      res_count    = count_ff;
      rsp_user_in  = pslt_pkg::STATUS_OK;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_tuser)
                  pslt_pkg::KIND_PUSH: begin
                     rsp_load = 1'b1;
                     if (count_ff == CW'(DEPTH)) begin
                        rsp_user_in = pslt_pkg::STATUS_FULL;
                     end else begin
                        ram_we    = 1'b1;
                        count_in  = count_ff + CW'(1);
                        res_count = count_ff + CW'(1);
                     end
                  end
                  pslt_pkg::KIND_POP: begin
                     if (count_ff == CW'(0)) begin
                        rsp_load    = 1'b1;
                        rsp_user_in = pslt_pkg::STATUS_EMPTY;
                     end else begin
                        ram_re    = 1'b1;
                        ram_raddr = count_m1;
                        addr_in   = count_m1;
                        first_in  = 1'b1;
                        state_in  = ST_SCAN;
                     end
                  end
                  pslt_pkg::KIND_CLEAR: begin
                     rsp_load  = 1'b1;
                     count_in  = '0;
                     res_count = '0;
                  end
                  default: begin
                     rsp_load = 1'b1;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            best_idx_in  = scan_idx;
            best_prio_in = scan_prio;
            best_val_in  = scan_val;
            first_in     = 1'b0;
            if (addr_ff != AW'(0)) begin
               ram_re    = 1'b1;
               ram_raddr = addr_ff - AW'(1);
               addr_in   = addr_ff - AW'(1);
            end else if (scan_idx != count_m1) begin
               ram_re    = 1'b1;
               ram_raddr = scan_idx + AW'(1);
               addr_in   = scan_idx + AW'(1);
               state_in  = ST_SHIFT;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_SHIFT: begin
            // entry at addr_ff moves one place down; the read runs ahead of the write
            ram_we    = 1'b1;
            ram_waddr = addr_ff - AW'(1);
            ram_wdata = ram_rdata;
            if (addr_ff != count_m1) begin
               ram_re    = 1'b1;
               ram_raddr = addr_ff + AW'(1);
               addr_in   = addr_ff + AW'(1);
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (slot_free) begin
               rsp_load  = 1'b1;
               res_val   = best_val_ff;
               res_count = count_dec;
               count_in  = count_dec;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_data_in  = {{pslt_pkg::RSP_PAD_W{1'b0}},
                      pslt_pkg::FILL_W'(res_count),
                      (res_count == CW'(0)),
                      pslt_pkg::OUT_VALUE_W'(res_val)};
      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff      <= addr_in;
      best_idx_ff  <= best_idx_in;
      best_prio_ff <= best_prio_in;
      best_val_ff  <= best_val_in;
      first_ff     <= first_in;
      if (rsp_load) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= rsp_user_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   assign finish_go = (state_ff == ST_FINISH) && slot_free;
   assign idle_rsp  = rsp_valid_ff && (state_ff == ST_IDLE);

   `PSLT_ASSERT_HOLDS(a_count_bound, count_ff <= CW'(DEPTH))
   `PSLT_ASSERT_IMP(a_shift_no_overlap, (state_ff == ST_SHIFT) && ram_re, ram_waddr < ram_raddr)
   `PSLT_ASSERT_NEXT(a_pop_done, finish_go, idle_rsp && (count_ff == $past(count_dec)))
   `PSLT_ASSERT_NEXT(a_quick_result, accept && (req_tuser != pslt_pkg::KIND_POP), idle_rsp)

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// testbench for the priority stack with latest-first order among equal priorities
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STACK_DEPTH = pslt_pkg::DEPTH_DEFAULT;
   localparam int REQ_W       =
      ((pslt_pkg::PRIO_WIDTH_DEFAULT + pslt_pkg::VALUE_WIDTH_DEFAULT + 7) / 8) * 8;
   localparam int QUIET_LIMIT = 2000;
   localparam int HOLD_CYCLES = 300;
   localparam int SETTLE_CYCLES = 40;
   localparam logic [pslt_pkg::KIND_W-1:0] KIND_NOP = 2'd3;

   typedef struct packed {
      logic [pslt_pkg::OUT_VALUE_W-1:0] value;
      logic [pslt_pkg::STATUS_W-1:0]    status;
      logic                             is_empty;
      logic [pslt_pkg::FILL_W-1:0]      fill;
   } stack_result_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [REQ_W-1:0]                req_tdata = '0;   // priority_req, value
   logic [pslt_pkg::KIND_W-1:0]     req_tuser = '0;   // kind
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [pslt_pkg::RSP_DATA_W-1:0] rsp_tdata;        // out_value, is_empty, fill_count
   logic [pslt_pkg::STATUS_W-1:0]   rsp_tuser;        // status

   priority_stack_lifo_ties uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // shadow copy of the stack
   logic [pslt_pkg::PRIO_WIDTH_DEFAULT-1:0]  stack_prio [STACK_DEPTH];
   logic [pslt_pkg::VALUE_WIDTH_DEFAULT-1:0] stack_val  [STACK_DEPTH];
   int                                       stack_fill = 0;

   stack_result_type pending_results[$];
   int  mismatch_count = 0;
   int  checked_count  = 0;
   int  push_count = 0, pop_count = 0, clear_count = 0, nop_count = 0;
   int  full_drops = 0, empty_pops = 0, tie_pops = 0, max_fill_seen = 0;
   int  quiet_cycles = 0;
   bit  tx_no_gaps = 1'b0;
   bit  rx_no_stalls = 1'b0;
   int  rsp_hold_cycles = 0;

   function automatic stack_result_type predict_stack_op(
         input logic [pslt_pkg::KIND_W-1:0] kind,
         input logic [7:0] prio,
         input logic [31:0] value);
      stack_result_type r;
      int               best;
      r = '0;
      r.status = pslt_pkg::STATUS_OK;
      case (kind)
         pslt_pkg::KIND_PUSH: begin
            if (stack_fill >= STACK_DEPTH) begin
               r.status = pslt_pkg::STATUS_FULL;
            end else begin
               stack_prio[stack_fill] = prio;
               stack_val[stack_fill]  = value;
               stack_fill++;
            end
         end
         pslt_pkg::KIND_POP: begin
            if (stack_fill == 0) begin
               r.status = pslt_pkg::STATUS_EMPTY;
            end else begin
               // scan downward, only a strictly larger priority takes over
               best = stack_fill - 1;
               for (int i = stack_fill - 2; i >= 0; i--) begin
                  if (stack_prio[i] > stack_prio[best]) best = i;
               end
               for (int i = 0; i < stack_fill; i++) begin
                  if (i != best && stack_prio[i] == stack_prio[best]) tie_pops++;
               end
               r.value = stack_val[best];
               for (int j = best; j + 1 < stack_fill; j++) begin
                  stack_prio[j] = stack_prio[j + 1];
                  stack_val[j]  = stack_val[j + 1];
               end
               stack_fill--;
            end
         end
         pslt_pkg::KIND_CLEAR: stack_fill = 0;
         default: ;
      endcase
      r.is_empty = (stack_fill == 0);
      r.fill     = stack_fill[pslt_pkg::FILL_W-1:0];
      return r;
   endfunction

   // predicts on every accepted word and checks every returned word
   always @(posedge clock) begin
      stack_result_type exp_r, got_r;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            exp_r = predict_stack_op(req_tuser, req_tdata[7:0], req_tdata[39:8]);
            pending_results.push_back(exp_r);
            case (req_tuser)
               pslt_pkg::KIND_PUSH:  push_count++;
               pslt_pkg::KIND_POP:   pop_count++;
               pslt_pkg::KIND_CLEAR: clear_count++;
               default:              nop_count++;
            endcase
            if (exp_r.status == pslt_pkg::STATUS_FULL) full_drops++;
            if (exp_r.status == pslt_pkg::STATUS_EMPTY) empty_pops++;
            if (stack_fill > max_fill_seen) max_fill_seen = stack_fill;
         end
         if (rsp_tvalid && rsp_tready) begin
            got_r.value    = rsp_tdata[31:0];
            got_r.is_empty = rsp_tdata[32];
            got_r.fill     = rsp_tdata[37:33];
            got_r.status   = rsp_tuser;
            if (pending_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: unexpected word value=%h status=%0d empty=%0b fill=%0d",
                           $realtime, got_r.value, got_r.status, got_r.is_empty, got_r.fill);
            end else begin
               exp_r = pending_results.pop_front();
               checked_count++;
               if (got_r.value !== exp_r.value || got_r.status !== exp_r.status ||
                   got_r.is_empty !== exp_r.is_empty || got_r.fill !== exp_r.fill) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("%0t: mismatch exp value=%h status=%0d empty=%0b fill=%0d",
                              $realtime, exp_r.value, exp_r.status, exp_r.is_empty,
                              exp_r.fill);
                     $display("%0t:          got value=%h status=%0d empty=%0b fill=%0d",
                              $realtime, got_r.value, got_r.status, got_r.is_empty,
                              got_r.fill);
                  end
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == QUIET_LIMIT) begin
            $display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   // result side: random stall (or none in no-stall stretches) before each word, or one long hold when asked
   initial begin
      int stall;
      do @(posedge clock); while (reset);
      forever begin
         if (rsp_hold_cycles > 0) begin
            stall = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end else begin
            stall = rx_no_stalls ? 0 : $urandom_range(0, 4);
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   task automatic send_word(input logic [pslt_pkg::KIND_W-1:0] kind, input logic [7:0] prio,
                            input logic [31:0] value);
      int gap;
      gap = tx_no_gaps ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {value, prio};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic wait_drained();
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic test_extremes_and_ties();
      send_word(pslt_pkg::KIND_POP, 8'd0, 32'd0);          // pop on empty store
      send_word(KIND_NOP, 8'hff, 32'hffff_ffff);
      send_word(pslt_pkg::KIND_CLEAR, 8'd0, 32'd0);
      send_word(pslt_pkg::KIND_PUSH, 8'd0, 32'h8000_0000);
      send_word(pslt_pkg::KIND_PUSH, 8'hff, 32'h7fff_ffff);
      send_word(pslt_pkg::KIND_PUSH, 8'hff, 32'hffff_ffff); // same priority, comes out first
      send_word(pslt_pkg::KIND_PUSH, 8'd0, 32'd0);
      send_word(KIND_NOP, 8'h5a, 32'h1234_5678);
      repeat (4) send_word(pslt_pkg::KIND_POP, 8'hff, 32'hffff_ffff);
      send_word(pslt_pkg::KIND_POP, 8'd0, 32'd0);
   endtask

   task automatic test_full_store();
      for (int i = 0; i < STACK_DEPTH; i++)
         send_word(pslt_pkg::KIND_PUSH, 8'(i % 4), $urandom);
      send_word(pslt_pkg::KIND_PUSH, 8'hff, $urandom);     // dropped, store is full
      send_word(pslt_pkg::KIND_POP, 8'd0, 32'd0);
      send_word(pslt_pkg::KIND_CLEAR, 8'hff, 32'hffff_ffff);
   endtask

   task automatic test_random_mix(input int n_items);
      int          push_pct, span, r;
      logic [7:0]  prio;
      logic [31:0] value;
      for (int n = 0; n < n_items; n++) begin
         if (n % 40 == 0) begin
            case ($urandom_range(0, 2))
               0: push_pct = 70;
               1: push_pct = 35;
               default: push_pct = 50;
            endcase
            span = $urandom_range(0, 2);
            tx_no_gaps   = ($urandom_range(0, 3) == 0);
            rx_no_stalls = ($urandom_range(0, 3) == 0);
         end
         case (span)
            0: prio = 8'($urandom_range(0, 3));   // lots of ties
            1: prio = 8'($urandom);
            default: prio = $urandom_range(0, 1) ? 8'hff - 8'($urandom_range(0, 1))
                                                 : 8'($urandom_range(0, 1));
         endcase
         case ($urandom_range(0, 7))
            0: value = 32'h8000_0000;
            1: value = 32'h7fff_ffff;
            default: value = $urandom;
         endcase
         r = $urandom_range(0, 99);
         if (r < 2) send_word(pslt_pkg::KIND_CLEAR, prio, value);
         else if (r < 4) send_word(KIND_NOP, prio, value);
         else if (r < 4 + push_pct) send_word(pslt_pkg::KIND_PUSH, prio, value);
         else send_word(pslt_pkg::KIND_POP, prio, value);
      end
   endtask

   // results are held back for a long stretch while words are offered with no gaps
   task automatic test_result_hold();
      tx_no_gaps = 1'b1;
      rsp_hold_cycles = HOLD_CYCLES;
      for (int i = 0; i < 30; i++)
         send_word(i % 3 == 2 ? pslt_pkg::KIND_POP : pslt_pkg::KIND_PUSH, 8'($urandom),
                   $urandom);
      tx_no_gaps = 1'b0;
   endtask

   task automatic test_pause_until_drained();
      for (int i = 0; i < 10; i++)
         send_word(pslt_pkg::KIND_PUSH, 8'($urandom_range(0, 7)), $urandom);
      req_tvalid <= 1'b0;
      wait_drained();
      for (int i = 0; i < 12; i++) send_word(pslt_pkg::KIND_POP, 8'd0, 32'd0);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_extremes_and_ties();
      test_full_store();
      test_random_mix(700);
      test_result_hold();
      test_pause_until_drained();
      test_random_mix(750);
      req_tvalid <= 1'b0;
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_results.size() != 0) mismatch_count++;
      $display("ran %0d pushes, %0d pops, %0d clears, %0d idle kinds; %0d words checked",
               push_count, pop_count, clear_count, nop_count, checked_count);
      $display("%0d pushes dropped on full, %0d pops on empty, %0d tie decisions, peak fill %0d",
               full_drops, empty_pops, tie_pops, max_fill_seen);
      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire
